FILE: hw/rtl/evq_pkg.sv
// evq_pkg: shared types and codes for the sorted event queue
// depends on nothing; imported by the channel interfaces, the cell and the top level
`timescale 1ns / 1ps

package evq_pkg;

  // width of the event kind tag
  localparam int unsigned KIND_W = 4;

  // opcode values
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // status codes of a result
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // accepted insert into a queue with room
    logic pop;  // accepted pop from a non-empty queue
  } evq_ctrl_t;

endpackage

FILE: hw/rtl/evq_if.sv
// evq_if: valid/ready channels for queue requests and results
// depends on evq_pkg for the kind width
`timescale 1ns / 1ps

interface evq_in_if
  import evq_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [KIND_W-1:0]     event_kind;
  logic [TIME_WIDTH-1:0] event_time;

  modport source (output valid, opcode, event_kind, event_time, input ready);
  modport sink   (input valid, opcode, event_kind, event_time, output ready);
endinterface

interface evq_out_if
  import evq_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32,
  parameter int unsigned CNT_W      = 5
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [KIND_W-1:0]     popped_kind;
  logic [TIME_WIDTH-1:0] popped_time;
  logic [CNT_W-1:0]      occupancy;

  modport source (output valid, status, popped_kind, popped_time, occupancy, input ready);
  modport sink   (input valid, status, popped_kind, popped_time, occupancy, output ready);
endinterface

FILE: hw/rtl/evq_cell.sv
// evq_cell: one slot of the sorted queue, exchanges its entry with its neighbors
// depends on evq_pkg for the command struct and kind width
`timescale 1ns / 1ps

module evq_cell
  import evq_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  evq_ctrl_t             ctrl_i,
  input  logic [TIME_WIDTH-1:0] new_time_i,
  input  logic [KIND_W-1:0]     new_kind_i,
  input  logic                  left_gt_i,
  input  logic                  left_valid_i,
  input  logic [TIME_WIDTH-1:0] left_time_i,
  input  logic [KIND_W-1:0]     left_kind_i,
  input  logic                  right_valid_i,
  input  logic [TIME_WIDTH-1:0] right_time_i,
  input  logic [KIND_W-1:0]     right_kind_i,
  output logic                  gt_o,
  output logic                  valid_o,
  output logic [TIME_WIDTH-1:0] time_o,
  output logic [KIND_W-1:0]     kind_o
);

  logic                  valid_q, valid_d;
  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic [KIND_W-1:0]     kind_q, kind_d;

  // new event goes at or before this slot: slot empty or holds a later time
  assign gt_o = !valid_q || (time_q > new_time_i);

  // insert shifts the tail right, pop shifts everything left
  always_comb begin
    valid_d = valid_q;
    time_d  = time_q;
    kind_d  = kind_q;
    if (ctrl_i.ins) begin
      if (left_gt_i) begin
        valid_d = left_valid_i;
        time_d  = left_time_i;
        kind_d  = left_kind_i;
      end else if (gt_o) begin
        valid_d = 1'b1;
        time_d  = new_time_i;
        kind_d  = new_kind_i;
      end
    end else if (ctrl_i.pop) begin
      valid_d = right_valid_i;
      time_d  = right_time_i;
      kind_d  = right_kind_i;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    kind_q <= kind_d;
  end

  assign valid_o = valid_q;
  assign time_o  = time_q;
  assign kind_o  = kind_q;

endmodule

FILE: hw/rtl/sorted_event_queue_top.sv
// A result is registered at the edge that accepts its request transaction
// and is offered on the result channel in the following cycle.
// Throughput: one insert or pop per cycle while results are taken; every cell of the row
// compares the new time at once and moves its entry by at most one slot per cycle.
// Reset: asynchronous, clears the cell occupancy flags, the entry count and the result valid
// flag; stored times and kinds and the result payload are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module sorted_event_queue_top
  import evq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  evq_in_if.sink    req_i,
  evq_out_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                  cell_gt    [DEPTH];
  logic [DEPTH-1:0]      cell_valid;
  logic [TIME_WIDTH-1:0] cell_time  [DEPTH];
  logic [KIND_W-1:0]     cell_kind  [DEPTH];
  logic [DEPTH-1:0]      order_ok;

  logic                  accept;
  logic                  is_pop;
  logic                  full;
  logic                  empty;
  evq_ctrl_t             ctrl;

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  rsp_valid_q;
  logic [1:0]            status_q, status_d;
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic [TIME_WIDTH-1:0] time_q, time_d;

  // request handshake, result register frees up when taken
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_pop      = (req_i.opcode == OP_POP);
  assign full        = cell_valid[DEPTH-1];
  assign empty       = !cell_valid[0];

  // command broadcast to the row
  assign ctrl.ins = accept && !is_pop && !full;
  assign ctrl.pop = accept && is_pop && !empty;

  // row of cells, slot 0 holds the earliest event
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  l_gt;
    logic                  l_valid;
    logic [TIME_WIDTH-1:0] l_time;
    logic [KIND_W-1:0]     l_kind;
    logic                  r_valid;
    logic [TIME_WIDTH-1:0] r_time;
    logic [KIND_W-1:0]     r_kind;

    if (i == 0) begin : g_first
      assign l_gt    = 1'b0;
      assign l_valid = 1'b0;
      assign l_time  = '0;
      assign l_kind  = '0;
    end else begin : g_mid_l
      assign l_gt    = cell_gt[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_time  = cell_time[i-1];
      assign l_kind  = cell_kind[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_valid     = 1'b0;
      assign r_time      = '0;
      assign r_kind      = '0;
      assign order_ok[i] = 1'b1;
    end else begin : g_mid_r
      assign r_valid     = cell_valid[i+1];
      assign r_time      = cell_time[i+1];
      assign r_kind      = cell_kind[i+1];
      assign order_ok[i] = !cell_valid[i+1] || (cell_time[i] <= cell_time[i+1]);
    end

    evq_cell #(
      .TIME_WIDTH (TIME_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_time_i    (req_i.event_time),
      .new_kind_i    (req_i.event_kind),
      .left_gt_i     (l_gt),
      .left_valid_i  (l_valid),
      .left_time_i   (l_time),
      .left_kind_i   (l_kind),
      .right_valid_i (r_valid),
      .right_time_i  (r_time),
      .right_kind_i  (r_kind),
      .gt_o          (cell_gt[i]),
      .valid_o       (cell_valid[i]),
      .time_o        (cell_time[i]),
      .kind_o        (cell_kind[i])
    );
  end

  // entry count and result payload
  always_comb begin
    cnt_d    = cnt_q;
    status_d = ST_DONE;
    kind_d   = '0;
    time_d   = '0;
    if (is_pop) begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        kind_d = cell_kind[0];
        time_d = cell_time[0];
        cnt_d  = cnt_q - CNT_W'(1);
      end
    end else begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q <= cnt_d;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      kind_q   <= kind_d;
      time_q   <= time_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.popped_kind = kind_q;
  assign rsp_o.popped_time = time_q;
  assign rsp_o.occupancy   = cnt_q;

`ifndef ASSERT_OFF
  // count tracks the number of occupied cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CNT_W'($countones(cell_valid)))
    else $error("entry count disagrees with occupied cells");

  // occupied cells form a packed run from slot 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("gap in occupied cells");

  // stored times stay ascending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    &order_ok)
    else $error("queue out of time order");

  // a pop on an empty row reports empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_pop && empty) |=> (rsp_o.valid && rsp_o.status == ST_EMPTY))
    else $error("empty pop not flagged");

  // an insert into a full row reports full and leaves the count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_pop && full) |=> (rsp_o.status == ST_FULL && $stable(cnt_q)))
    else $error("full insert not flagged");
`endif

endmodule
